// ===== hw/rtl/pfn_pkg.sv =====
// Shared constants for the polygon face normal core.
package pfn_pkg;

   localparam int COORD_WIDTH_DEF      = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   localparam int NORM_MAG_W  = 30;
   localparam int NORM_ROOT_W = NORM_MAG_W + 1;
   localparam int NORM_SUM_W  = 2 * NORM_MAG_W + 2;

endpackage

// ===== hw/rtl/pfn_req_if.sv =====
// Request channel: one polygon word.
interface pfn_req_if import pfn_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                       valid;
   logic                       ready;
   logic                       is_triangle;
   logic [3*COORD_WIDTH-1:0]   vertex_a;
   logic [3*COORD_WIDTH-1:0]   vertex_b;
   logic [3*COORD_WIDTH-1:0]   vertex_c;
   logic [3*COORD_WIDTH-1:0]   vertex_d;

   modport source (output valid, is_triangle, vertex_a, vertex_b, vertex_c, vertex_d,
                   input ready);
   modport sink   (input valid, is_triangle, vertex_a, vertex_b, vertex_c, vertex_d,
                   output ready);
endinterface

// ===== hw/rtl/pfn_rsp_if.sv =====
// Response channel: one normal word.
interface pfn_rsp_if import pfn_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) ();
   localparam int NW = NORMAL_FRAC_BITS + 2;
   logic                 valid;
   logic                 ready;
   logic                 split_choice;
   logic signed [NW-1:0] face_x;
   logic signed [NW-1:0] face_y;
   logic signed [NW-1:0] face_z;
   logic signed [NW-1:0] half_one_x;
   logic signed [NW-1:0] half_one_y;
   logic signed [NW-1:0] half_one_z;
   logic signed [NW-1:0] half_two_x;
   logic signed [NW-1:0] half_two_y;
   logic signed [NW-1:0] half_two_z;
   logic                 degenerate;

   modport source (output valid, split_choice, face_x, face_y, face_z, half_one_x,
                   half_one_y, half_one_z, half_two_x, half_two_y, half_two_z,
                   degenerate, input ready);
   modport sink   (input valid, split_choice, face_x, face_y, face_z, half_one_x,
                   half_one_y, half_one_z, half_two_x, half_two_y, half_two_z,
                   degenerate, output ready);
endinterface

// ===== hw/rtl/polygon_face_normal_core.sv =====
// Top level: diagonal split, two normal lanes and the merging normalizer.
//
//   port       role     word
//   req_chan   sink     is_triangle, vertex_a..vertex_d
//   rsp_chan   source   split_choice, face/half_one/half_two normals, degenerate
//
// One word enters per cycle while no held response stalls the pipeline; its depth is
// set by the bit-per-stage square root and divider in each normalizer.
// Reset is synchronous and clears only the valid bits.
// A held response stalls the whole pipeline; req_chan.ready drops only then.
module polygon_face_normal_core import pfn_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pfn_req_if.sink    req_chan,
   pfn_rsp_if.source  rsp_chan
);
   localparam int CW   = COORD_WIDTH;
   localparam int OW   = NORMAL_FRAC_BITS + 2;
   localparam int DFW  = CW + 1;
   localparam int SQW  = 2 * CW + 2;
   localparam int SUMW = SQW + 2;
   localparam int MSW  = OW + 1;

   typedef struct packed {
      logic is_tri;
      logic split;
   } lane_side_type;

   typedef struct packed {
      logic               is_tri;
      logic               split;
      logic               z1;
      logic               z2;
      logic [2:0][OW-1:0] h1;
      logic [2:0][OW-1:0] h2;
   } merge_side_type;

   localparam int LSW = $bits(lane_side_type);
   localparam int MSDW = $bits(merge_side_type);

   logic                    en;
   logic [3:0][2:0][CW-1:0] vin;
   logic                    v0_ff, v1_ff, vl_ff, vm_ff;
   logic                    tri0_ff, tri1_ff;
   logic [3:0][2:0][CW-1:0] vt0_ff, vt1_ff;
   logic [2:0][DFW-1:0]     dac_ff, dac_in, dbd_ff, dbd_in;
   logic [2:0][SQW-1:0]     sac_ff, sac_in, sbd_ff, sbd_in;
   logic [SUMW-1:0]         sum_ac, sum_bd;
   logic                    split_in;
   logic [2:0][CW-1:0]      l1p_ff [0:2];
   logic [2:0][CW-1:0]      l1p_in [0:2];
   logic [2:0][CW-1:0]      l2p_ff [0:2];
   logic [2:0][CW-1:0]      l2p_in [0:2];
   lane_side_type           lside_ff, lside_in, l1_side, l2_side;
   logic                    l1_valid, l2_valid, l1_zero, l2_zero;
   logic [2:0][OW-1:0]      l1_vec, l2_vec;
   merge_side_type          mside_ff, mside_in, fside;
   logic [2:0][MSW-1:0]     msum_ff, msum_in;
   logic                    f_valid, f_zero;
   logic [2:0][OW-1:0]      f_vec;
   logic [MSDW-1:0]         fside_bits;

   logic                    rv_ff;
   logic                    rsplit_ff, rdeg_ff;
   logic [2:0][OW-1:0]      rface_ff, rh1_ff, rh2_ff;
   logic [2:0][OW-1:0]      rface_in, rh2_in;
   logic                    rdeg_in;

   assign en             = !rv_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vin[0][k] = req_chan.vertex_a[k*CW +: CW];
         vin[1][k] = req_chan.vertex_b[k*CW +: CW];
         vin[2][k] = req_chan.vertex_c[k*CW +: CW];
         vin[3][k] = req_chan.vertex_d[k*CW +: CW];
         dac_in[k] = {vin[0][k][CW-1], vin[0][k]} - {vin[2][k][CW-1], vin[2][k]};
         dbd_in[k] = {vin[1][k][CW-1], vin[1][k]} - {vin[3][k][CW-1], vin[3][k]};
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sac_in[k] = SQW'($signed(dac_ff[k]) * $signed(dac_ff[k]));
         sbd_in[k] = SQW'($signed(dbd_ff[k]) * $signed(dbd_ff[k]));
      end
   end

   always_comb begin
      sum_ac   = SUMW'(sac_ff[0]) + SUMW'(sac_ff[1]) + SUMW'(sac_ff[2]);
      sum_bd   = SUMW'(sbd_ff[0]) + SUMW'(sbd_ff[1]) + SUMW'(sbd_ff[2]);
      split_in = !tri1_ff && !(sum_ac < sum_bd);
      lside_in.is_tri = tri1_ff;
      lside_in.split  = split_in;
      if (split_in) begin
         l1p_in[0] = vt1_ff[0];
         l1p_in[1] = vt1_ff[1];
         l1p_in[2] = vt1_ff[3];
         l2p_in[0] = vt1_ff[1];
         l2p_in[1] = vt1_ff[2];
         l2p_in[2] = vt1_ff[3];
      end else begin
         l1p_in[0] = vt1_ff[0];
         l1p_in[1] = vt1_ff[1];
         l1p_in[2] = vt1_ff[2];
         l2p_in[0] = vt1_ff[0];
         l2p_in[1] = vt1_ff[2];
         l2p_in[2] = vt1_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         vl_ff <= 1'b0;
         vm_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_chan.valid;
         v1_ff <= v0_ff;
         vl_ff <= v1_ff;
         vm_ff <= l1_valid;
         rv_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tri0_ff  <= req_chan.is_triangle;
         vt0_ff   <= vin;
         dac_ff   <= dac_in;
         dbd_ff   <= dbd_in;
         tri1_ff  <= tri0_ff;
         vt1_ff   <= vt0_ff;
         sac_ff   <= sac_in;
         sbd_ff   <= sbd_in;
         lside_ff <= lside_in;
         for (int n = 0; n < 3; n++) begin
            l1p_ff[n] <= l1p_in[n];
            l2p_ff[n] <= l2p_in[n];
         end
         mside_ff <= mside_in;
         msum_ff  <= msum_in;
      end
   end

   pfn_lane #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .SIDE_W           (LSW)
   ) u_lane_one (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vl_ff),
      .p0        (l1p_ff[0]),
      .p1        (l1p_ff[1]),
      .p2        (l1p_ff[2]),
      .in_side   (lside_ff),
      .out_valid (l1_valid),
      .out_zero  (l1_zero),
      .out_vec   (l1_vec),
      .out_side  (l1_side)
   );

   pfn_lane #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .SIDE_W           (LSW)
   ) u_lane_two (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vl_ff),
      .p0        (l2p_ff[0]),
      .p1        (l2p_ff[1]),
      .p2        (l2p_ff[2]),
      .in_side   (lside_ff),
      .out_valid (l2_valid),
      .out_zero  (l2_zero),
      .out_vec   (l2_vec),
      .out_side  (l2_side)
   );

   always_comb begin
      mside_in.is_tri = l1_side.is_tri;
      mside_in.split  = l1_side.split;
      mside_in.z1     = l1_zero;
      mside_in.z2     = l2_zero;
      mside_in.h1     = l1_vec;
      mside_in.h2     = l2_vec;
      for (int k = 0; k < 3; k++) begin
         msum_in[k] = {l1_vec[k][OW-1], l1_vec[k]} + {l2_vec[k][OW-1], l2_vec[k]};
      end
   end

   pfn_norm #(
      .IN_W   (MSW),
      .SIDE_W (MSDW),
      .FRAC   (NORMAL_FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vm_ff),
      .in_vec    (msum_ff),
      .in_side   (mside_ff),
      .out_valid (f_valid),
      .out_zero  (f_zero),
      .out_vec   (f_vec),
      .out_side  (fside_bits)
   );

   assign fside = merge_side_type'(fside_bits);

   always_comb begin
      if (fside.is_tri) begin
         rface_in = fside.h1;
         rh2_in   = fside.h1;
         rdeg_in  = fside.z1;
      end else begin
         rface_in = f_vec;
         rh2_in   = fside.h2;
         rdeg_in  = fside.z1 || fside.z2 || f_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsplit_ff <= fside.split;
         rface_ff  <= rface_in;
         rh1_ff    <= fside.h1;
         rh2_ff    <= rh2_in;
         rdeg_ff   <= rdeg_in;
      end
   end

   assign rsp_chan.valid        = rv_ff;
   assign rsp_chan.split_choice = rsplit_ff;
   assign rsp_chan.face_x       = rface_ff[0];
   assign rsp_chan.face_y       = rface_ff[1];
   assign rsp_chan.face_z       = rface_ff[2];
   assign rsp_chan.half_one_x   = rh1_ff[0];
   assign rsp_chan.half_one_y   = rh1_ff[1];
   assign rsp_chan.half_one_z   = rh1_ff[2];
   assign rsp_chan.half_two_x   = rh2_ff[0];
   assign rsp_chan.half_two_y   = rh2_ff[1];
   assign rsp_chan.half_two_z   = rh2_ff[2];
   assign rsp_chan.degenerate   = rdeg_ff;

   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      l1_valid == l2_valid && (!l1_valid || l1_side == l2_side))
      else $error("lanes out of step");

   a_tri_no_split : assert property (@(posedge clock) disable iff (reset)
      f_valid && fside.is_tri |-> !fside.split)
      else $error("triangle marked as split along b-d");

   a_face_nonzero : assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rdeg_ff |-> (rface_ff[0] != '0 || rface_ff[1] != '0 || rface_ff[2] != '0))
      else $error("non-degenerate word with zero face normal");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rv_ff)
      else $error("input stalled with empty output register");

endmodule

// ===== hw/rtl/pfn_norm.sv =====
// Pipelined vector normalizer: scale, square root and divide, one bit a stage.
module pfn_norm import pfn_pkg::*; #(
   parameter int IN_W   = 35,
   parameter int SIDE_W = 1,
   parameter int FRAC   = NORMAL_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [2:0][IN_W-1:0]    in_vec,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic                    out_zero,
   output logic [2:0][FRAC+1:0]    out_vec,
   output logic [SIDE_W-1:0]       out_side
);
   localparam int MW = NORM_MAG_W;
   localparam int RW = NORM_ROOT_W;
   localparam int SW = NORM_SUM_W;
   localparam int PW = $clog2(IN_W);
   localparam int XW = IN_W + MW;
   localparam int DW = RW + FRAC + 1;
   localparam int DS = FRAC + 1;
   localparam int QW = FRAC + 1;
   localparam int OW = FRAC + 2;

   typedef struct packed {
      logic                     zero;
      logic [2:0]               neg;
      logic [2:0][MW-1:0]       mag;
      logic [SIDE_W-1:0]        side;
   } carry_type;

   logic                    v0_ff, v1_ff, v2_ff, v3_ff;
   logic [2:0]              neg0_ff, neg0_in, neg1_ff;
   logic [2:0][IN_W-1:0]    mag0_ff, mag0_in, mag1_ff;
   logic [SIDE_W-1:0]       side0_ff, side1_ff;
   logic [IN_W-1:0]         orr;
   logic [PW-1:0]           pos_ff, pos_in;
   logic                    zero1_ff;
   carry_type               c2_ff, c2_in, c3_ff;
   logic [2:0][2*MW-1:0]    sq3_ff, sq3_in;

   logic [SW-1:0]           rem_ff [0:RW];
   logic [SW-1:0]           rem_in [0:RW];
   logic [RW-1:0]           root_ff [0:RW];
   logic [RW-1:0]           root_in [0:RW];
   carry_type               cs_ff [0:RW];
   logic                    vs_ff [0:RW];

   logic [2:0][DW-1:0]      drem_ff [0:DS];
   logic [2:0][DW-1:0]      drem_in [0:DS];
   logic [2:0][QW-1:0]      dq_ff [0:DS];
   logic [2:0][QW-1:0]      dq_in [0:DS];
   logic [RW-1:0]           dl_ff [0:DS-1];
   logic [RW-1:0]           dl_in [0:DS-1];
   carry_type               dc_ff [0:DS];
   logic                    dv_ff [0:DS];

   logic                    ov_ff;
   logic                    oz_ff;
   logic [2:0][OW-1:0]      ovec_ff, ovec_in;
   logic [SIDE_W-1:0]       oside_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg0_in[k] = in_vec[k][IN_W-1];
         mag0_in[k] = neg0_in[k] ? (~in_vec[k] + IN_W'(1)) : in_vec[k];
      end
   end

   always_comb begin
      orr    = mag0_ff[0] | mag0_ff[1] | mag0_ff[2];
      pos_in = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (orr[i]) begin
            pos_in = PW'(i);
         end
      end
   end

   always_comb begin
      logic [XW-1:0] ext;
      ext = '0;
      c2_in.zero = zero1_ff;
      c2_in.neg  = neg1_ff;
      c2_in.side = side1_ff;
      for (int k = 0; k < 3; k++) begin
         ext = {mag1_ff[k], MW'(0)} >> ({1'b0, pos_ff} + (PW+1)'(1));
         c2_in.mag[k] = ext[MW-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq3_in[k] = c2_ff.mag[k] * c2_ff.mag[k];
      end
   end

   always_comb begin
      logic [SW:0] trial;
      logic        ge;
      int          i;
      trial = '0;
      ge    = 1'b0;
      i     = 0;
      rem_in[0]  = SW'(sq3_ff[0]) + SW'(sq3_ff[1]) + SW'(sq3_ff[2]);
      root_in[0] = '0;
      for (int k = 0; k < RW; k++) begin
         i     = RW - 1 - k;
         trial = ((SW+1)'(root_ff[k]) << (i + 1)) | ((SW+1)'(1) << (2 * i));
         ge    = {1'b0, rem_ff[k]} >= trial;
         rem_in[k+1]  = ge ? rem_ff[k] - trial[SW-1:0] : rem_ff[k];
         root_in[k+1] = ge ? (root_ff[k] | (RW'(1) << i)) : root_ff[k];
      end
   end

   always_comb begin
      logic [DW-1:0] dsh;
      int            j;
      dsh = '0;
      j   = 0;
      for (int k = 0; k < 3; k++) begin
         drem_in[0][k] = (DW'(cs_ff[RW].mag[k]) << FRAC) + DW'(root_ff[RW] >> 1);
      end
      dq_in[0] = '0;
      dl_in[0] = root_ff[RW];
      for (int s = 0; s < DS; s++) begin
         j   = FRAC - s;
         dsh = DW'(dl_ff[s]) << j;
         for (int k = 0; k < 3; k++) begin
            if (drem_ff[s][k] >= dsh) begin
               drem_in[s+1][k] = drem_ff[s][k] - dsh;
               dq_in[s+1][k]   = dq_ff[s][k] | (QW'(1) << j);
            end else begin
               drem_in[s+1][k] = drem_ff[s][k];
               dq_in[s+1][k]   = dq_ff[s][k];
            end
         end
      end
      for (int s = 1; s < DS; s++) begin
         dl_in[s] = dl_ff[s-1];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dc_ff[DS].zero) begin
            ovec_in[k] = '0;
         end else if (dc_ff[DS].neg[k]) begin
            ovec_in[k] = OW'(0) - OW'(dq_ff[DS][k]);
         end else begin
            ovec_in[k] = OW'(dq_ff[DS][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k <= RW; k++) vs_ff[k] <= 1'b0;
         for (int s = 0; s <= DS; s++) dv_ff[s] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v0_ff    <= in_valid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vs_ff[0] <= v3_ff;
         for (int k = 0; k < RW; k++) vs_ff[k+1] <= vs_ff[k];
         dv_ff[0] <= vs_ff[RW];
         for (int s = 0; s < DS; s++) dv_ff[s+1] <= dv_ff[s];
         ov_ff    <= dv_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff  <= neg0_in;
         mag0_ff  <= mag0_in;
         side0_ff <= in_side;
         neg1_ff  <= neg0_ff;
         mag1_ff  <= mag0_ff;
         side1_ff <= side0_ff;
         pos_ff   <= pos_in;
         zero1_ff <= (orr == '0);
         c2_ff    <= c2_in;
         c3_ff    <= c2_ff;
         sq3_ff   <= sq3_in;
         cs_ff[0] <= c3_ff;
         for (int k = 0; k <= RW; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         for (int k = 0; k < RW; k++) cs_ff[k+1] <= cs_ff[k];
         for (int s = 0; s <= DS; s++) begin
            drem_ff[s] <= drem_in[s];
            dq_ff[s]   <= dq_in[s];
         end
         for (int s = 0; s < DS; s++) dl_ff[s] <= dl_in[s];
         dc_ff[0] <= cs_ff[RW];
         for (int s = 0; s < DS; s++) dc_ff[s+1] <= dc_ff[s];
         ovec_ff  <= ovec_in;
         oz_ff    <= dc_ff[DS].zero;
         oside_ff <= dc_ff[DS].side;
      end
   end

   assign out_valid = ov_ff;
   assign out_zero  = oz_ff;
   assign out_vec   = ovec_ff;
   assign out_side  = oside_ff;

endmodule

// ===== hw/rtl/pfn_lane.sv =====
// One lane: edge vectors, cross product and negated unit normal.
module pfn_lane import pfn_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
   parameter int SIDE_W           = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [2:0][COORD_WIDTH-1:0]       p0,
   input  logic [2:0][COORD_WIDTH-1:0]       p1,
   input  logic [2:0][COORD_WIDTH-1:0]       p2,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic                              out_zero,
   output logic [2:0][NORMAL_FRAC_BITS+1:0]  out_vec,
   output logic [SIDE_W-1:0]                 out_side
);
   localparam int CW  = COORD_WIDTH;
   localparam int EW  = CW + 1;
   localparam int PRW = 2 * CW + 2;
   localparam int XW  = 2 * CW + 3;
   localparam int OW  = NORMAL_FRAC_BITS + 2;

   logic                  ve_ff, vp_ff, vx_ff;
   logic [SIDE_W-1:0]     se_ff, sp_ff, sx_ff;
   logic [2:0][EW-1:0]    e1_ff, e1_in, e2_ff, e2_in;
   logic signed [PRW-1:0] pr_ff [0:5];
   logic signed [PRW-1:0] pr_in [0:5];
   logic [2:0][XW-1:0]    cx_ff, cx_in;
   logic [2:0][OW-1:0]    nrm_vec;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1_in[k] = {p1[k][CW-1], p1[k]} - {p0[k][CW-1], p0[k]};
         e2_in[k] = {p2[k][CW-1], p2[k]} - {p0[k][CW-1], p0[k]};
      end
   end

   always_comb begin
      pr_in[0] = $signed(e1_ff[1]) * $signed(e2_ff[2]);
      pr_in[1] = $signed(e1_ff[2]) * $signed(e2_ff[1]);
      pr_in[2] = $signed(e1_ff[2]) * $signed(e2_ff[0]);
      pr_in[3] = $signed(e1_ff[0]) * $signed(e2_ff[2]);
      pr_in[4] = $signed(e1_ff[0]) * $signed(e2_ff[1]);
      pr_in[5] = $signed(e1_ff[1]) * $signed(e2_ff[0]);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cx_in[k] = XW'(pr_ff[2*k]) - XW'(pr_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vp_ff <= 1'b0;
         vx_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= in_valid;
         vp_ff <= ve_ff;
         vx_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         se_ff <= in_side;
         for (int m = 0; m < 6; m++) pr_ff[m] <= pr_in[m];
         sp_ff <= se_ff;
         cx_ff <= cx_in;
         sx_ff <= sp_ff;
      end
   end

   pfn_norm #(
      .IN_W   (XW),
      .SIDE_W (SIDE_W),
      .FRAC   (NORMAL_FRAC_BITS)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vx_ff),
      .in_vec    (cx_ff),
      .in_side   (sx_ff),
      .out_valid (out_valid),
      .out_zero  (out_zero),
      .out_vec   (nrm_vec),
      .out_side  (out_side)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         out_vec[k] = OW'(0) - nrm_vec[k];
      end
   end

endmodule
